>>> src/ppsr_pkg.sv
// Shared constants and types for the particle pool spawn and retire block.
// Used by ppsr_engine and particle_pool_spawn_and_retire; no dependencies.
`timescale 1ns / 1ps

package ppsr_pkg;

   localparam int POOL_DEPTH_DEF = 256;

   localparam int ACC_W       = 17;
   localparam int LIFE_W      = 17;
   localparam int CNT_W       = 9;
   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_SPAWN_INCREMENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEFAULT_LIFE    = 2'd1;

   localparam logic [CFG_W-1:0] SPAWN_INCREMENT_RST = 16'd0;
   localparam logic [CFG_W-1:0] DEFAULT_LIFE_RST    = 16'd60;

   typedef struct packed {
      logic [CFG_W-1:0] spawn_increment;
      logic [CFG_W-1:0] default_life_ticks;
   } cfg_type;

endpackage

>>> src/ppsr_life_ram.sv
// Lifetime store: one write port, one read port with registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module ppsr_life_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 17
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ppsr_engine.sv
// Tick sequencer: spawn into the pool, then age and compact it in place; a report item skips both.
// Depends on ppsr_pkg and ppsr_life_ram.
`timescale 1ns / 1ps

module ppsr_engine #(
   parameter int POOL_DEPTH = ppsr_pkg::POOL_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ppsr_pkg::cfg_type          cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_advance,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ppsr_pkg::CNT_W-1:0] rsp_live_count,
   output logic [ppsr_pkg::CNT_W-1:0] rsp_spawned_count,
   output logic [ppsr_pkg::CNT_W-1:0] rsp_retired_count
);

   localparam int LW = $clog2(POOL_DEPTH + 1);
   localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = (LW > ppsr_pkg::CNT_W) ? LW : ppsr_pkg::CNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SPAWN,
      S_AGE_START,
      S_AGE_EVAL,
      S_FINISH
   } state_type;

   state_type                    state_ff;
   logic [ppsr_pkg::ACC_W-1:0]  acc_ff;
   logic [LW-1:0]               live_ff;
   logic [LW-1:0]               idx_ff;
   logic [ppsr_pkg::CNT_W-1:0]  want_ff;
   logic [ppsr_pkg::CNT_W-1:0]  spawned_ff;
   logic [LW-1:0]               retired_ff;
   logic                        rsp_valid_ff;
   logic [ppsr_pkg::CNT_W-1:0]  rsp_live_ff;
   logic [ppsr_pkg::CNT_W-1:0]  rsp_spawned_ff;
   logic [ppsr_pkg::CNT_W-1:0]  rsp_retired_ff;

   logic [ppsr_pkg::ACC_W-1:0]  acc_sum;
   logic [ppsr_pkg::CNT_W-1:0]  acc_int;
   logic                        pool_full;
   logic signed [ppsr_pkg::LIFE_W-1:0] new_life;
   logic signed [ppsr_pkg::LIFE_W-1:0] rd_life;
   logic signed [ppsr_pkg::LIFE_W-1:0] aged_life;
   logic                        alive;
   logic [LW-1:0]               idx_next;
   logic [LW-1:0]               live_less;
   logic [CW-1:0]               live_wide;
   logic [CW-1:0]               retired_wide;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [ppsr_pkg::LIFE_W-1:0] wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [ppsr_pkg::LIFE_W-1:0] rd_data;

   assign acc_sum   = acc_ff + {1'b0, cfg.spawn_increment};
   assign acc_int   = acc_sum[ppsr_pkg::ACC_W-1:8];
   assign pool_full = (live_ff >= LW'(POOL_DEPTH));
   assign new_life  = $signed({1'b0, cfg.default_life_ticks}) - 17'sd1;
   assign rd_life   = $signed(rd_data);
   assign aged_life = rd_life - 17'sd1;
   assign alive     = (aged_life > 17'sd0);
   assign idx_next  = idx_ff + 1'b1;
   assign live_less = live_ff - 1'b1;
   assign live_wide    = CW'(live_ff);
   assign retired_wide = CW'(retired_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = live_ff[AW-1:0];
      wr_data = new_life;
      rd_en   = 1'b0;
      rd_addr = idx_next[AW-1:0];
      unique case (state_ff)
         S_SPAWN: begin
            wr_en = (want_ff != '0) && !pool_full;
         end
         S_AGE_START: begin
            rd_en   = (live_ff != '0);
            rd_addr = '0;
         end
         S_AGE_EVAL: begin
            if (alive) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[AW-1:0];
               wr_data = aged_life;
               rd_en   = (idx_next < live_ff);
               rd_addr = idx_next[AW-1:0];
            end else begin
               rd_en   = (idx_ff < live_less);
               rd_addr = live_less[AW-1:0];
            end
         end
         S_IDLE, S_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  spawned_ff <= '0;
                  retired_ff <= '0;
                  if (req_advance) begin
                     want_ff  <= acc_int;
                     acc_ff   <= (acc_int != '0) ? '0 : acc_sum;
                     state_ff <= S_SPAWN;
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_SPAWN: begin
               if ((want_ff != '0) && !pool_full) begin
                  live_ff    <= live_ff + 1'b1;
                  spawned_ff <= spawned_ff + 1'b1;
                  want_ff    <= want_ff - 1'b1;
               end else begin
                  state_ff <= S_AGE_START;
               end
            end
            S_AGE_START: begin
               idx_ff   <= '0;
               state_ff <= (live_ff != '0) ? S_AGE_EVAL : S_FINISH;
            end
            S_AGE_EVAL: begin
               if (alive) begin
                  idx_ff <= idx_next;
                  if (idx_next >= live_ff) begin
                     state_ff <= S_FINISH;
                  end
               end else begin
                  live_ff    <= live_less;
                  retired_ff <= retired_ff + 1'b1;
                  if (idx_ff >= live_less) begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_live_ff    <= live_wide[ppsr_pkg::CNT_W-1:0];
                  rsp_spawned_ff <= spawned_ff;
                  rsp_retired_ff <= retired_wide[ppsr_pkg::CNT_W-1:0];
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   ppsr_life_ram #(
      .DEPTH  (POOL_DEPTH),
      .ADDR_W (AW),
      .DATA_W (ppsr_pkg::LIFE_W)
   ) u_life_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_live_count    = rsp_live_ff;
   assign rsp_spawned_count = rsp_spawned_ff;
   assign rsp_retired_count = rsp_retired_ff;

endmodule

>>> src/particle_pool_spawn_and_retire.sv
// Particle pool spawn and retire: one item at a time. A report item goes from the idle
// state to the finish state, which loads the result; a tick spawns, then ages and compacts
// the pool, one pool entry per cycle through the lifetime RAM, before the finish state.
// Next item is taken once the result is loaded; a result still waiting holds the load.
// Synchronous reset clears the live count, accumulator and pending result, sets
// spawn_increment to 0 and default_life_ticks to 60; the lifetime RAM is not swept.
`timescale 1ns / 1ps

module particle_pool_spawn_and_retire #(
   parameter int POOL_DEPTH = ppsr_pkg::POOL_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_advance,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ppsr_pkg::CNT_W-1:0]       rsp_live_count,
   output logic [ppsr_pkg::CNT_W-1:0]       rsp_spawned_count,
   output logic [ppsr_pkg::CNT_W-1:0]       rsp_retired_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ppsr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ppsr_pkg::CFG_W-1:0]       csr_data
);

   ppsr_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spawn_increment    <= ppsr_pkg::SPAWN_INCREMENT_RST;
         cfg_ff.default_life_ticks <= ppsr_pkg::DEFAULT_LIFE_RST;
      end else if (csr_valid) begin
         if (csr_index == ppsr_pkg::REG_SPAWN_INCREMENT) begin
            cfg_ff.spawn_increment <= csr_data;
         end else if (csr_index == ppsr_pkg::REG_DEFAULT_LIFE) begin
            cfg_ff.default_life_ticks <= csr_data;
         end
      end
   end

   assign csr_ready = 1'b1;

   ppsr_engine #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_advance       (req_advance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_live_count    (rsp_live_count),
      .rsp_spawned_count (rsp_spawned_count),
      .rsp_retired_count (rsp_retired_count)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("engine still ready right after taking an item");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an item in progress");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((POOL_DEPTH > 511) || (rsp_live_count <= POOL_DEPTH)))
      else $error("live count exceeds pool depth");

   a_spawn_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((POOL_DEPTH > 511) || (rsp_spawned_count <= POOL_DEPTH)))
      else $error("spawned count exceeds pool depth");

endmodule

>>> bench/tb_particle_pool_spawn_and_retire.sv
// Self-checking bench for particle_pool_spawn_and_retire: random stalls, config phases,
// pool fill, drop and retire cases, each result compared with an in-bench pool model.
// Depends on ppsr_pkg and the particle_pool_spawn_and_retire RTL only.
`timescale 1ns / 1ps

module tb_particle_pool_spawn_and_retire;

   localparam int POOL = ppsr_pkg::POOL_DEPTH_DEF;
   localparam logic [ppsr_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;
   localparam int HOLD_AT       = 200;
   localparam int HOLD_CYCLES   = 3000;
   localparam int PHASE_ITEMS   = 50;
   localparam int RANDOM_PHASES = 23;

   typedef struct packed {
      logic [ppsr_pkg::CNT_W-1:0] live;
      logic [ppsr_pkg::CNT_W-1:0] spawned;
      logic [ppsr_pkg::CNT_W-1:0] retired;
   } pool_counts_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_advance = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [ppsr_pkg::CNT_W-1:0]       rsp_live_count;
   logic [ppsr_pkg::CNT_W-1:0]       rsp_spawned_count;
   logic [ppsr_pkg::CNT_W-1:0]       rsp_retired_count;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [ppsr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ppsr_pkg::CFG_W-1:0]       csr_data = '0;

   // pool model state
   logic [ppsr_pkg::CFG_W-1:0]         cfg_increment = ppsr_pkg::SPAWN_INCREMENT_RST;
   logic [ppsr_pkg::CFG_W-1:0]         cfg_life = ppsr_pkg::DEFAULT_LIFE_RST;
   logic [ppsr_pkg::ACC_W-1:0]         spawn_acc = '0;
   int unsigned                        pool_live = 0;
   logic signed [ppsr_pkg::LIFE_W-1:0] pool_life [POOL];

   logic            pending_items [$];
   pool_counts_type expected_counts [$];

   int items_queued = 0;
   int items_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int send_idle_pct = 35;
   int recv_idle_pct = 71;
   int hold_left = 0;
   logic hold_fired = 1'b0;

   int stat_ticks = 0;
   int stat_reports = 0;
   int stat_spawned = 0;
   int stat_retired = 0;
   int stat_drop_ticks = 0;
   int stat_cfg_writes = 0;

   particle_pool_spawn_and_retire dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_advance       (req_advance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_live_count    (rsp_live_count),
      .rsp_spawned_count (rsp_spawned_count),
      .rsp_retired_count (rsp_retired_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   // run one item through the pool model and return its counts
   function automatic pool_counts_type advance_pool(input logic do_tick);
      pool_counts_type counts;
      int unsigned     want;
      int unsigned     idx;
      int unsigned     spawned;
      int unsigned     retired;
      spawned = 0;
      retired = 0;
      if (do_tick) begin
         stat_ticks++;
         spawn_acc = spawn_acc + ppsr_pkg::ACC_W'(cfg_increment);
         want = 32'(spawn_acc[ppsr_pkg::ACC_W-1:8]);
         if (want != 0) begin
            while (want > 0 && pool_live < POOL) begin
               pool_life[pool_live] = $signed({1'b0, cfg_life}) - 17'sd1;
               pool_live++;
               spawned++;
               want--;
            end
            if (want > 0)
               stat_drop_ticks++;
            spawn_acc = '0;
         end
         idx = 0;
         while (idx < pool_live) begin
            pool_life[idx] = pool_life[idx] - 17'sd1;
            if (pool_life[idx] <= 17'sd0) begin
               pool_life[idx] = pool_life[pool_live - 1];
               pool_live--;
               retired++;
            end else begin
               idx++;
            end
         end
         stat_spawned += int'(spawned);
         stat_retired += int'(retired);
      end else begin
         stat_reports++;
      end
      counts.live    = ppsr_pkg::CNT_W'(pool_live);
      counts.spawned = ppsr_pkg::CNT_W'(spawned);
      counts.retired = ppsr_pkg::CNT_W'(retired);
      return counts;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("tb: mismatch on %s at result %0d: got %0d, want %0d",
               what, results_seen, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : drive_req
      logic next_valid;
      logic next_advance;
      if (reset) begin
         req_valid   <= 1'b0;
         req_advance <= 1'b0;
      end else begin
         next_valid   = req_valid;
         next_advance = req_advance;
         if (req_valid && req_ready) begin
            expected_counts.push_back(advance_pool(req_advance));
            items_sent <= items_sent + 1;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_items.size() != 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            next_valid   = 1'b1;
            next_advance = pending_items.pop_front();
         end
         req_valid   <= next_valid;
         req_advance <= next_advance;
      end
   end

   always @(posedge clock) begin : check_rsp
      pool_counts_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = expected_counts.pop_front();
               if (rsp_live_count !== want.live)
                  report_mismatch("live_count", int'(rsp_live_count), int'(want.live));
               if (rsp_spawned_count !== want.spawned)
                  report_mismatch("spawned_count", int'(rsp_spawned_count),
                                  int'(want.spawned));
               if (rsp_retired_count !== want.retired)
                  report_mismatch("retired_count", int'(rsp_retired_count),
                                  int'(want.retired));
            end
            results_seen <= results_seen + 1;
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // hold the receiver off once so the block fills and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_fired <= 1'b0;
      end else if (!hold_fired && items_sent >= HOLD_AT) begin
         hold_left  <= HOLD_CYCLES;
         hold_fired <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic write_reg(input logic [ppsr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ppsr_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      unique case (idx)
         ppsr_pkg::REG_SPAWN_INCREMENT: cfg_increment = value;
         ppsr_pkg::REG_DEFAULT_LIFE:    cfg_life = value;
         default: ;
      endcase
      stat_cfg_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_items(input logic advance_list [$]);
      foreach (advance_list[k])
         pending_items.push_back(advance_list[k]);
      items_queued += advance_list.size();
      do @(posedge clock); while (results_seen < items_queued);
   endtask

   initial begin
      logic                       phase_items [$];
      logic [ppsr_pkg::CFG_W-1:0] inc;
      logic [ppsr_pkg::CFG_W-1:0] life;
      int                         pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: report, idle tick, unused register, short and long lives
      queue_items('{1'b0, 1'b1});
      write_reg(REG_UNUSED, 16'hFFFF);
      queue_items('{1'b1});
      write_reg(ppsr_pkg::REG_SPAWN_INCREMENT, 16'h0100);
      write_reg(ppsr_pkg::REG_DEFAULT_LIFE, 16'd1);
      queue_items('{1'b1, 1'b1});
      write_reg(ppsr_pkg::REG_DEFAULT_LIFE, 16'hFFFF);
      queue_items('{1'b1, 1'b0});
      write_reg(ppsr_pkg::REG_SPAWN_INCREMENT, 16'h0180);
      write_reg(ppsr_pkg::REG_DEFAULT_LIFE, 16'd3);
      queue_items('{1'b1, 1'b1, 1'b1, 1'b1});
      // fill the pool, drop the overflow, then retire in bulk through swapped entries
      write_reg(ppsr_pkg::REG_SPAWN_INCREMENT, 16'hFFFF);
      write_reg(ppsr_pkg::REG_DEFAULT_LIFE, 16'd4);
      queue_items('{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1});
      write_reg(ppsr_pkg::REG_SPAWN_INCREMENT, 16'h0000);
      write_reg(ppsr_pkg::REG_DEFAULT_LIFE, 16'd2);
      queue_items('{1'b1, 1'b1});
      write_reg(ppsr_pkg::REG_SPAWN_INCREMENT, 16'h00FF);
      queue_items('{1'b1, 1'b1, 1'b1});

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 8) begin
            send_idle_pct = 35;
            recv_idle_pct = 71;
         end else if (p < 16) begin
            send_idle_pct = 71;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick = $urandom_range(0, 9);
         if (pick == 0)
            inc = 16'($urandom_range(16'h8000, 16'hFFFF));
         else if (pick == 1)
            inc = '0;
         else
            inc = 16'($urandom_range(0, 16'h0300));
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            life = 16'd1;
         end else if (pick == 1) begin
            life = 16'($urandom_range(300, 65535));
            inc  = 16'($urandom_range(0, 32));
         end else begin
            life = 16'($urandom_range(2, 48));
         end
         write_reg(ppsr_pkg::REG_SPAWN_INCREMENT, inc);
         write_reg(ppsr_pkg::REG_DEFAULT_LIFE, life);
         phase_items.delete();
         repeat (PHASE_ITEMS)
            phase_items.push_back($urandom_range(0, 99) < 85);
         queue_items(phase_items);
      end

      repeat (20) @(posedge clock);
      $display("tb: %0d ticks and %0d report items, %0d particles spawned, %0d retired",
               stat_ticks, stat_reports, stat_spawned, stat_retired);
      $display("tb: %0d ticks dropped spawns on a full pool, %0d register writes, hold of %0d",
               stat_drop_ticks, stat_cfg_writes, HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("tb: timeout after %0d results", results_seen);
      $display("tb: failure");
      $finish;
   end

endmodule
